FILE: rtl/core/bounded_stack_with_palindrome_check_top_assert.svh
// Assertion macros for the stack block; each expects clk and rst in scope.
`ifndef BOUNDED_STACK_WITH_PALINDROME_CHECK_TOP_ASSERT_SVH
`define BOUNDED_STACK_WITH_PALINDROME_CHECK_TOP_ASSERT_SVH

// same-cycle implication
`define BSPC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bspc_pkg.sv
// Shared constants and types for the bounded stack block.
package bspc_pkg;

  localparam int DEPTH  = 8;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 4;
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_DISP = 2'd2;
  localparam logic [1:0] MODE_PAL  = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_UNF = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ONE,
    S_POP,
    S_DISP,
    S_PAL
  } state_t;

endpackage

FILE: rtl/core/bspc_ram.sv
// Generic RAM: one write port, two registered read ports.
module bspc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

FILE: rtl/core/bounded_stack_with_palindrome_check_top.sv
// Bounded LIFO stack with display and palindrome walk over a two-read RAM.
// Push, pop and palindrome on an empty stack: the result passes through S_ONE to the output register.
// Display of n entries: results from S_DISP, one per cycle while the output is not stalled,
//   paced by the RAM read port. Palindrome of n entries: cursors walk inward in S_PAL, then S_ONE.
// Push or pop: the next request is taken once the last result is loaded.
// Reset (rst, synchronous): stack empty, capacity 8; RAM contents are not cleared.
`include "bounded_stack_with_palindrome_check_top_assert.svh"

module bounded_stack_with_palindrome_check_top
  import bspc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               mode,
  input  logic signed [DATA_W-1:0] push_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] data,
  output logic                     is_palindrome,
  output logic                     last
);

  state_t state, state_next;

  logic [CAP_W-1:0]  capacity;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] addr0, addr0_next;
  logic [ADDR_W-1:0] addr1, addr1_next;
  logic [1:0]        res_status, res_status_next;
  logic              res_pal, res_pal_next;
  logic              same, same_next;

  logic              we;
  logic [DATA_W-1:0] rdata0, rdata1;

  logic              accept, slot_free, emit;
  logic [1:0]        e_status;
  logic [DATA_W-1:0] e_data;
  logic              e_pal, e_last;

  logic [CMP_W-1:0]  cap_ext, cap_eff;
  logic              overflow, empty, eq, pal_done;
  logic [CNT_W-1:0]  cnt_dec;
  logic [ADDR_W-1:0] top_addr;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  assign cap_ext  = CMP_W'(capacity);
  assign cap_eff  = (cap_ext < CMP_W'(DEPTH)) ? cap_ext : CMP_W'(DEPTH);
  assign overflow = CMP_W'(count) >= cap_eff;
  assign empty    = (count == '0);
  assign cnt_dec  = count - CNT_W'(1);
  assign top_addr = cnt_dec[ADDR_W-1:0];
  assign eq       = (rdata0 == rdata1);
  // the two cursors have met or crossed after this compare
  assign pal_done = ({1'b0, addr1} <= ({1'b0, addr0} + (ADDR_W + 1)'(1)));

  // RAM addresses are the next cursor values, so read data always matches addr0/addr1
  bspc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (count[ADDR_W-1:0]),
    .wdata  (push_value),
    .raddr0 (addr0_next),
    .raddr1 (addr1_next),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_PUSH: state_next = S_ONE;
            MODE_POP:  state_next = empty ? S_ONE : S_POP;
            MODE_DISP: state_next = empty ? S_ONE : S_DISP;
            default:   state_next = empty ? S_ONE : S_PAL;
          endcase
        end
      end
      S_ONE:  if (slot_free) state_next = S_IDLE;
      S_POP:  if (slot_free) state_next = S_IDLE;
      S_DISP: if (slot_free && addr0 == '0) state_next = S_IDLE;
      S_PAL:  if (pal_done) state_next = S_ONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we              = 1'b0;
    count_next      = count;
    addr0_next      = addr0;
    addr1_next      = addr1;
    res_status_next = res_status;
    res_pal_next    = res_pal;
    same_next       = same;
    emit            = 1'b0;
    e_status        = ST_OK;
    e_data          = '0;
    e_pal           = 1'b0;
    e_last          = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_pal_next = 1'b0;
          case (mode)
            MODE_PUSH: begin
              if (overflow) begin
                res_status_next = ST_OVF;
              end else begin
                we              = 1'b1;
                count_next      = count + CNT_W'(1);
                res_status_next = ST_OK;
              end
            end
            MODE_POP: begin
              if (empty) begin
                res_status_next = ST_UNF;
              end else begin
                addr0_next = top_addr;
                count_next = cnt_dec;
              end
            end
            MODE_DISP: begin
              if (empty) begin
                res_status_next = ST_UNF;
              end else begin
                addr0_next = top_addr;
              end
            end
            default: begin
              res_status_next = ST_OK;
              if (empty) begin
                res_pal_next = 1'b1;
              end else begin
                addr0_next = '0;
                addr1_next = top_addr;
                same_next  = 1'b1;
              end
            end
          endcase
        end
      end
      S_ONE: begin
        emit     = slot_free;
        e_status = res_status;
        e_pal    = res_pal;
      end
      S_POP: begin
        emit   = slot_free;
        e_data = rdata0;
      end
      S_DISP: begin
        emit   = slot_free;
        e_data = rdata0;
        e_last = (addr0 == '0);
        if (slot_free && addr0 != '0) begin
          addr0_next = addr0 - ADDR_W'(1);
        end
      end
      S_PAL: begin
        same_next = same && eq;
        if (pal_done) begin
          res_status_next = ST_OK;
          res_pal_next    = same && eq;
        end else begin
          addr0_next = addr0 + ADDR_W'(1);
          addr1_next = addr1 - ADDR_W'(1);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      capacity  <= CAP_RESET;
      out_valid <= 1'b0;
      addr0     <= '0;
      addr1     <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      addr0 <= addr0_next;
      addr1 <= addr1_next;
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_pal    <= res_pal_next;
    same       <= same_next;
    if (emit) begin
      status        <= e_status;
      data          <= e_data;
      is_palindrome <= e_pal;
      last          <= e_last;
    end
  end

  `BSPC_ASSERT_IMPL(a_count_bound, 1'b1, CMP_W'(count) <= CMP_W'(DEPTH), "count beyond depth")
  `BSPC_ASSERT_IMPL(a_mid_ok, out_valid && !last, status == ST_OK, "non-final result not ok")
  `BSPC_ASSERT_IMPL(a_pal_last, out_valid && is_palindrome, last, "palindrome flag on non-final")
  `BSPC_ASSERT_IMPL(a_pal_order, state == S_PAL, addr0 <= addr1, "palindrome cursors crossed")
  `BSPC_ASSERT_NEXT(a_pop_dec, accept && mode == MODE_POP && !empty,
                    count == $past(cnt_dec), "pop did not decrement count")

endmodule

FILE: tb/stack_result_checker.sv
// Checker for the bounded stack: mirrors the stack, predicts each request's results, compares.
`timescale 1ns / 1ps

module stack_result_checker
  import bspc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [1:0]               mode,
  input  logic signed [DATA_W-1:0] push_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [1:0]               status,
  input  logic signed [DATA_W-1:0] data,
  input  logic                     is_palindrome,
  input  logic                     last,
  output int                       mismatch_count,
  output int                       results_due
);

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic                     pal;
    logic                     last;
  } stack_result_t;

  stack_result_t            stack_results_due[$];
  logic signed [DATA_W-1:0] shadow_entries[DEPTH];
  int unsigned              shadow_count;
  logic [CAP_W-1:0]         shadow_capacity;
  int                       errors_seen;

  function automatic void queue_result(input logic [1:0] st, input logic signed [DATA_W-1:0] d,
                                       input logic pal, input logic lst);
    stack_result_t r;
    r.status = st;
    r.data   = d;
    r.pal    = pal;
    r.last   = lst;
    stack_results_due.push_back(r);
  endfunction

  function automatic void apply_stack_request(input logic [1:0] m,
                                              input logic signed [DATA_W-1:0] v);
    int unsigned eff_cap;
    bit          same;
    // capacity above the storage size is clipped to the storage size
    eff_cap = (shadow_capacity < DEPTH) ? shadow_capacity : DEPTH;
    case (m)
      MODE_PUSH: begin
        if (shadow_count >= eff_cap) begin
          queue_result(ST_OVF, '0, 1'b0, 1'b1);
        end else begin
          shadow_entries[shadow_count] = v;
          shadow_count++;
          queue_result(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      MODE_POP: begin
        if (shadow_count == 0) begin
          queue_result(ST_UNF, '0, 1'b0, 1'b1);
        end else begin
          shadow_count--;
          queue_result(ST_OK, shadow_entries[shadow_count], 1'b0, 1'b1);
        end
      end
      MODE_DISP: begin
        if (shadow_count == 0) begin
          queue_result(ST_UNF, '0, 1'b0, 1'b1);
        end else begin
          for (int j = shadow_count; j > 0; j--)
            queue_result(ST_OK, shadow_entries[j-1], 1'b0, j == 1);
        end
      end
      default: begin
        same = 1'b1;
        for (int j = 0; j < shadow_count; j++)
          if (shadow_entries[j] !== shadow_entries[shadow_count-1-j]) same = 1'b0;
        queue_result(ST_OK, '0, same, 1'b1);
      end
    endcase
  endfunction

  function automatic void note_mismatch(input string what, input stack_result_t want,
                                        input stack_result_t seen);
    errors_seen++;
    if (errors_seen <= 10)
      $display("%t %s: expected status %0d data %0d pal %0b last %0b, got status %0d data %0d pal %0b last %0b",
               $realtime, what, want.status, want.data, want.pal, want.last,
               seen.status, seen.data, seen.pal, seen.last);
  endfunction

  initial errors_seen = 0;

  always @(posedge clk) begin : watch
    stack_result_t seen;
    stack_result_t want;
    if (rst) begin
      stack_results_due.delete();
      shadow_count    = 0;
      shadow_capacity = CAP_RESET;
    end else begin
      // result side first: a request taken this edge cannot answer this edge
      if (out_valid && out_ready) begin
        seen.status = status;
        seen.data   = data;
        seen.pal    = is_palindrome;
        seen.last   = last;
        if (stack_results_due.size() == 0) begin
          note_mismatch("result with nothing outstanding", '0, seen);
        end else begin
          want = stack_results_due.pop_front();
          if (seen.status !== want.status || seen.data !== want.data ||
              seen.pal !== want.pal || seen.last !== want.last)
            note_mismatch("result mismatch", want, seen);
        end
      end
      if (cfg_we) shadow_capacity = cfg_data;
      if (in_valid && in_ready) apply_stack_request(mode, push_value);
    end
    results_due    <= stack_results_due.size();
    mismatch_count <= errors_seen;
  end

endmodule

FILE: tb/tb.sv
// Top of the stack testbench: clock, reset, request stimulus, capacity writes and verdict.
`timescale 1ns / 1ps

module tb;
  import bspc_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic                     clk        = 1'b0;
  logic                     rst        = 1'b1;
  logic                     cfg_we     = 1'b0;
  logic [CAP_W-1:0]         cfg_data   = '0;
  logic                     in_valid   = 1'b0;
  logic [1:0]               mode       = MODE_PUSH;
  logic signed [DATA_W-1:0] push_value = '0;
  logic                     out_ready  = 1'b0;
  logic                     in_ready;
  logic                     out_valid;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data;
  logic                     is_palindrome;
  logic                     last;

  int mismatch_count;
  int results_due;
  int send_idle_pct  = 13;
  int recv_stall_pct = 70;
  int quiet_cycles   = 0;

  bounded_stack_with_palindrome_check_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .push_value(push_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .data(data), .is_palindrome(is_palindrome), .last(last)
  );

  stack_result_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .push_value(push_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .data(data), .is_palindrome(is_palindrome), .last(last),
    .mismatch_count(mismatch_count), .results_due(results_due)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(9))
      0:       return {1'b1, {(DATA_W-1){1'b0}}};
      1:       return {1'b0, {(DATA_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // valid is only dropped for an idle gap, never between back-to-back transfers
  task automatic send_request(input logic [1:0] m, input logic signed [DATA_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    push_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CAP_W-1:0]         caps[8];
    logic signed [DATA_W-1:0] mirror[DEPTH];
    int                       len;
    int                       pick;
    caps = '{4'd1, 4'd8, 4'd3, 4'd15, 4'd0, 4'd5, 4'd2, 4'd8};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty stack: palindrome holds, pop and display underflow
    send_request(MODE_PAL, rand_word());
    send_request(MODE_POP, rand_word());
    send_request(MODE_DISP, rand_word());
    send_request(MODE_PUSH, 32'sh8000_0000);
    send_request(MODE_PUSH, 32'sh7FFF_FFFF);
    send_request(MODE_PUSH, 32'sh7FFF_FFFF);
    send_request(MODE_PUSH, 32'sh8000_0000);
    send_request(MODE_PAL, '0);
    send_request(MODE_PUSH, 32'sh5555_5555);
    send_request(MODE_PUSH, 32'shAAAA_AAAA);
    send_request(MODE_PUSH, '0);
    send_request(MODE_PUSH, '1);
    send_request(MODE_PUSH, 32'sh1234_5678);   // full: overflow
    send_request(MODE_DISP, '1);
    send_request(MODE_PAL, '1);
    send_request(MODE_POP, '0);
    send_request(MODE_POP, '0);
    // capacity dropped below the fill level
    set_capacity(4'd2);
    send_request(MODE_PUSH, 32'sh0BAD_F00D);
    send_request(MODE_POP, '0);
    send_request(MODE_DISP, '0);
    set_capacity(4'd0);
    send_request(MODE_PUSH, '1);
    set_capacity(4'd15);
    send_request(MODE_PUSH, 32'sh0000_0001);

    for (int s = 0; s < 8; s++) begin
      if (s == 3) begin
        send_idle_pct  = 70;
        recv_stall_pct = 13;
      end else if (s == 6) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      set_capacity(caps[s]);
      // drain, then load a mirrored sequence, sometimes with one bit broken
      repeat (DEPTH) send_request(MODE_POP, rand_word());
      len = $urandom_range(DEPTH, 1);
      for (int i = 0; i < (len + 1) / 2; i++) begin
        mirror[i]         = rand_word();
        mirror[len-1-i]   = mirror[i];
      end
      if ($urandom_range(3) == 0) begin
        pick         = $urandom_range(len - 1);
        mirror[pick] = mirror[pick] ^ (32'sd1 << $urandom_range(DATA_W - 1));
      end
      for (int i = 0; i < len; i++) send_request(MODE_PUSH, mirror[i]);
      send_request(MODE_PAL, rand_word());
      send_request(MODE_DISP, rand_word());
      repeat (6) begin
        pick = $urandom_range(99);
        if (pick < 40)      send_request(MODE_PUSH, rand_word());
        else if (pick < 65) send_request(MODE_POP, rand_word());
        else if (pick < 80) send_request(MODE_DISP, rand_word());
        else                send_request(MODE_PAL, rand_word());
      end
    end

    wait_drained();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/bspc_pkg.sv
rtl/core/bspc_ram.sv
rtl/core/bounded_stack_with_palindrome_check_top.sv
tb/stack_result_checker.sv
tb/tb.sv
